@@ hdl/sct_pkg.sv @@
// Shared types and constants for the shell command tokenizer.
// Holds the lexer modes, token kinds, character codes, the item/bundle types and the lexer state.
// No dependencies.
package sct_pkg;

  // Lexer modes.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_AMP     = 4'd1,
    MODE_GT      = 4'd2,
    MODE_LT      = 4'd3,
    MODE_TWO     = 4'd4,
    MODE_ERRT    = 4'd5,
    MODE_QUOTE   = 4'd6,
    MODE_LIT     = 4'd7,
    MODE_DISCARD = 4'd8
  } mode_e;

  // Token kinds as seen on the result channel.
  typedef enum logic [3:0] {
    KIND_LIT      = 4'd0,
    KIND_SQ       = 4'd1,
    KIND_DQ       = 4'd2,
    KIND_APPEND   = 4'd3,
    KIND_TRUNC    = 4'd4,
    KIND_HEREDOC  = 4'd5,
    KIND_INFILE   = 4'd6,
    KIND_PIPE     = 4'd7,
    KIND_ERRREDIR = 4'd8,
    KIND_SEMI     = 4'd9,
    KIND_AND      = 4'd10,
    KIND_END      = 4'd11
  } kind_e;

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_PIPE  = 8'h7c;

  // Most result items one input byte can cause.
  localparam int unsigned MAX_ITEMS = 3;

  // One result item.
  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    kind_e      kind;
    logic       first;
    logic       last;
    logic       err;
  } item_t;

  // All result items caused by one input byte.
  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic  [1:0]           cnt;
  } bundle_t;

  // Lexer state carried from byte to byte.
  typedef struct packed {
    mode_e      mode;
    logic [7:0] held_char;
    logic       held_valid;
    logic       open_quote;
    logic       started;
  } lex_st_t;

endpackage

@@ hdl/sct_front.sv @@
// Front end of the shell command tokenizer: takes one byte per cycle while
// acc is high, runs the lexer state machine and produces a bundle of up to
// three result items. Depends on sct_pkg.
module sct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  output logic              push,
  output sct_pkg::bundle_t  bundle
);
  import sct_pkg::*;

  lex_st_t st_r;
  lex_st_t st_nxt;
  bundle_t bun_nxt;

  // Append one item to a bundle.
  function automatic void put(inout bundle_t b, input logic [7:0] ch, input logic v,
                              input kind_e k, input logic f, input logic l, input logic e);
    item_t it;
    it.ch       = ch;
    it.ch_valid = v;
    it.kind     = k;
    it.first    = f;
    it.last     = l;
    it.err      = e;
    if (b.cnt < 2'd3) begin
      b.items[b.cnt] = it;
      b.cnt          = b.cnt + 2'd1;
    end
  endfunction

  function automatic logic is_lit_delim(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_AMP) || (c == CH_GT) || (c == CH_LT) ||
           (c == CH_PIPE) || (c == CH_SEMI) || (c == CH_LF);
  endfunction

  // Error item; the rest of the command is skipped.
  function automatic void raise_error(inout lex_st_t s, inout bundle_t b);
    put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b1);
    s.mode       = MODE_DISCARD;
    s.held_valid = 1'b0;
    s.held_char  = CH_NUL;
    s.started    = 1'b0;
  endfunction

  // Flush the held byte as the last of its token, or an empty token.
  function automatic void close_held(inout lex_st_t s, inout bundle_t b, input kind_e k);
    if (s.held_valid) begin
      put(b, s.held_char, 1'b1, k, ~s.started, 1'b1, 1'b0);
    end else begin
      put(b, CH_NUL, 1'b0, k, 1'b1, 1'b1, 1'b0);
    end
    s.held_valid = 1'b0;
    s.held_char  = CH_NUL;
    s.started    = 1'b0;
  endfunction

  // Emit the held byte (not last) and hold the new one.
  function automatic void push_byte(inout lex_st_t s, inout bundle_t b,
                                    input logic [7:0] c, input kind_e k);
    if (s.held_valid) begin
      put(b, s.held_char, 1'b1, k, ~s.started, 1'b0, 1'b0);
      s.started = 1'b1;
    end
    s.held_char  = c;
    s.held_valid = 1'b1;
  endfunction

  // Classify the first byte of a new token.
  function automatic void start_token(inout lex_st_t s, inout bundle_t b, input logic [7:0] c);
    s.held_valid = 1'b0;
    s.held_char  = CH_NUL;
    s.started    = 1'b0;
    case (c) inside
      CH_SPACE, CH_TAB, CH_CR, CH_LF: s.mode = MODE_IDLE;
      CH_AMP: s.mode = MODE_AMP;
      CH_PIPE: begin
        put(b, CH_PIPE, 1'b1, KIND_PIPE, 1'b1, 1'b1, 1'b0);
        s.mode = MODE_IDLE;
      end
      CH_SEMI: begin
        put(b, CH_SEMI, 1'b1, KIND_SEMI, 1'b1, 1'b1, 1'b0);
        s.mode = MODE_IDLE;
      end
      CH_GT: s.mode = MODE_GT;
      CH_LT: s.mode = MODE_LT;
      CH_TWO: s.mode = MODE_TWO;
      CH_SQUOT: begin
        s.mode       = MODE_QUOTE;
        s.open_quote = 1'b0;
      end
      CH_DQUOT: begin
        s.mode       = MODE_QUOTE;
        s.open_quote = 1'b1;
      end
      default: begin
        s.mode       = MODE_LIT;
        s.held_char  = c;
        s.held_valid = 1'b1;
      end
    endcase
  endfunction

  function automatic void lit_byte(inout lex_st_t s, inout bundle_t b, input logic [7:0] c);
    if (is_lit_delim(c)) begin
      close_held(s, b, KIND_LIT);
      start_token(s, b, c);
    end else begin
      push_byte(s, b, c, KIND_LIT);
    end
  endfunction

  // Next state and result bundle for the incoming byte.
  always_comb begin : lex_step
    lex_st_t s;
    bundle_t b;
    kind_e   qkind;
    logic [7:0] qchar;
    s     = st_r;
    b     = '0;
    qkind = st_r.open_quote ? KIND_DQ : KIND_SQ;
    qchar = st_r.open_quote ? CH_DQUOT : CH_SQUOT;

    unique case (st_r.mode)
      MODE_IDLE: start_token(s, b, byte_in);
      MODE_AMP: begin
        if (byte_in == CH_AMP) begin
          put(b, CH_AMP, 1'b1, KIND_AND, 1'b1, 1'b0, 1'b0);
          put(b, CH_AMP, 1'b1, KIND_AND, 1'b0, 1'b1, 1'b0);
          s.mode = MODE_IDLE;
        end else begin
          raise_error(s, b);
        end
      end
      MODE_GT: begin
        if (byte_in == CH_GT) begin
          put(b, CH_GT, 1'b1, KIND_APPEND, 1'b1, 1'b0, 1'b0);
          put(b, CH_GT, 1'b1, KIND_APPEND, 1'b0, 1'b1, 1'b0);
          s.mode = MODE_IDLE;
        end else begin
          put(b, CH_GT, 1'b1, KIND_TRUNC, 1'b1, 1'b1, 1'b0);
          start_token(s, b, byte_in);
        end
      end
      MODE_LT: begin
        if (byte_in == CH_LT) begin
          put(b, CH_LT, 1'b1, KIND_HEREDOC, 1'b1, 1'b0, 1'b0);
          put(b, CH_LT, 1'b1, KIND_HEREDOC, 1'b0, 1'b1, 1'b0);
          s.mode = MODE_IDLE;
        end else begin
          put(b, CH_LT, 1'b1, KIND_INFILE, 1'b1, 1'b1, 1'b0);
          start_token(s, b, byte_in);
        end
      end
      MODE_TWO: begin
        if (byte_in == CH_GT) begin
          s.mode       = MODE_ERRT;
          s.held_valid = 1'b0;
          s.started    = 1'b0;
        end else begin
          s.mode       = MODE_LIT;
          s.held_char  = CH_TWO;
          s.held_valid = 1'b1;
          s.started    = 1'b0;
          lit_byte(s, b, byte_in);
        end
      end
      MODE_ERRT: begin
        if (byte_in == CH_SPACE || byte_in == CH_LF) begin
          close_held(s, b, KIND_ERRREDIR);
          s.mode = MODE_IDLE;
        end else begin
          push_byte(s, b, byte_in, KIND_ERRREDIR);
        end
      end
      MODE_QUOTE: begin
        if (byte_in == qchar) begin
          close_held(s, b, qkind);
          s.mode = MODE_IDLE;
        end else begin
          push_byte(s, b, byte_in, qkind);
        end
      end
      MODE_LIT: lit_byte(s, b, byte_in);
      default: s.mode = MODE_DISCARD;
    endcase

    // Close out the command on its final byte.
    if (last_in) begin
      unique case (s.mode)
        MODE_IDLE: put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        MODE_AMP, MODE_QUOTE: raise_error(s, b);
        MODE_GT: begin
          put(b, CH_GT, 1'b1, KIND_TRUNC, 1'b1, 1'b1, 1'b0);
          put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        end
        MODE_LT: begin
          put(b, CH_LT, 1'b1, KIND_INFILE, 1'b1, 1'b1, 1'b0);
          put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        end
        MODE_TWO: begin
          put(b, CH_TWO, 1'b1, KIND_LIT, 1'b1, 1'b1, 1'b0);
          put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        end
        MODE_LIT: begin
          close_held(s, b, KIND_LIT);
          put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        end
        MODE_ERRT: begin
          close_held(s, b, KIND_ERRREDIR);
          put(b, CH_NUL, 1'b0, KIND_END, 1'b1, 1'b1, 1'b0);
        end
        default: ;
      endcase
      s = '{mode: MODE_IDLE, held_char: CH_NUL, held_valid: 1'b0,
            open_quote: 1'b0, started: 1'b0};
    end

    st_nxt  = s;
    bun_nxt = b;
  end

  // Lexer state register, advanced once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_IDLE, held_char: CH_NUL, held_valid: 1'b0,
                open_quote: 1'b0, started: 1'b0};
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

  assign push   = acc && (bun_nxt.cnt != 2'd0);
  assign bundle = bun_nxt;

endmodule

@@ hdl/sct_back.sv @@
// Back end of the shell command tokenizer: a short queue of item bundles and
// the output stage that hands them out one item per cycle unless out_stall is
// high. Depends on sct_pkg.
module sct_back #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sct_pkg::bundle_t  bundle,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output sct_pkg::item_t    out_item
);
  import sct_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  bundle_t          q_mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    q_cnt_r;
  bundle_t          cur_r;
  logic             cur_valid_r;
  logic [1:0]       idx_r;
  logic             take, done, load;

  // Output-stage handshake and queue pop.
  assign take = cur_valid_r && !out_stall;
  assign done = take && (idx_r == cur_r.cnt - 2'd1);
  assign load = (!cur_valid_r || done) && (q_cnt_r != '0);
  assign full = (q_cnt_r == CW'(DEPTH));

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= bundle;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (load) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      q_cnt_r <= q_cnt_r + CW'(push) - CW'(load);
    end
  end

  // Current bundle and the index of the item on the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_mem[rd_ptr_r];
    end
  end

  assign out_valid = cur_valid_r;
  assign out_item  = cur_r.items[idx_r];

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into a full bundle queue");

  // The fill count stays within the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CW'(DEPTH)) else $error("queue count above depth");

  // A bundle on the output always has an item at the current index.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.cnt != 2'd0) && (idx_r < cur_r.cnt))
    else $error("output index past bundle end");

  // An error item is always a complete, closing item.
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && out_item.err) |-> (out_item.first && out_item.last &&
                                       out_item.kind == KIND_END))
    else $error("malformed error item");

endmodule

@@ hdl/shell_command_tokenizer_top.sv @@
// Top level of the shell command tokenizer: lexer front end feeding a bundle
// queue and output stage. Depends on sct_pkg, sct_front and sct_back.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------------
//  in_      | in_valid / in_stall  | in_byte, in_last_byte
//  out_     | out_valid / out_stall| out_char, out_char_valid, out_token_kind,
//           |                      | out_token_first, out_token_last, out_lex_error
//
// One input byte is accepted per cycle while the bundle queue has room; the
// lexer state updates in that same cycle. Results leave one item per cycle while
// out_stall is low, so a byte causing two or three items (&&, >>, << or a command
// end) holds the output stage for each; its first item passes the bundle queue and
// the current-bundle register. Reset is synchronous, active low, and returns the
// lexer to between tokens with an empty queue. in_stall rises only when the
// QUEUE_DEPTH bundle queue is full; out_stall holds the current item in place.
module shell_command_tokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic [3:0] out_token_kind,
  output logic       out_token_first,
  output logic       out_token_last,
  output logic       out_lex_error
);
  import sct_pkg::*;

  logic    in_acc;
  logic    push;
  logic    full;
  bundle_t bundle;
  item_t   item;

  assign in_stall = full;
  assign in_acc   = in_valid && !full;

  // Lexer front end.
  sct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .byte_in (in_byte),
    .last_in (in_last_byte),
    .push    (push),
    .bundle  (bundle)
  );

  // Bundle queue and item output stage.
  sct_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bundle    (bundle),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (item)
  );

  assign out_char        = item.ch;
  assign out_char_valid  = item.ch_valid;
  assign out_token_kind  = item.kind;
  assign out_token_first = item.first;
  assign out_token_last  = item.last;
  assign out_lex_error   = item.err;

endmodule
